### hw/rtl/dpc_pkg.sv
// dpc_pkg: shared widths, constants and the log table builder
// for the dew point and unit conversion block; no dependencies
package dpc_pkg;

   // field widths
   localparam int TEMP_W = 11;
   localparam int HUM_W  = 10;
   localparam int FAHR_W = 12;
   localparam int KELV_W = 13;
   localparam int DEW_W  = 11;
   localparam int OFS_W  = 13;

   // log table
   localparam int LOG_TABLE_ENTRIES_DEF = 64;
   localparam int LOG_VAL_W             = 16;
   localparam int FRAC_W                = 15;

   // magnus coefficients scaled by 100 and 1000, log constants in q16.16
   localparam int B_X100     = 1762;
   localparam int C_X1000    = 243120;
   localparam int LN2_Q16    = 45426;
   localparam int LN1000_Q16 = 452707;
   localparam int B_Q16      = B_X100 * 65536;

   // unit conversion constants
   localparam int FAHR_OFS   = 320;
   localparam int FAHR_RECIP = 13108;   // ceil(2^16 / 5)
   localparam int FAHR_MAX   = 2047;
   localparam int FAHR_MIN   = -2048;
   localparam int KELV_MAX   = 4095;
   localparam int KELV_MIN   = -4096;
   localparam int DEW_MAX    = 1023;
   localparam int DEW_MIN    = -1000;

   localparam int KELVIN_OFFSET_RST = -2732;

   // 2*atanh(u) series in q30, u given in q30, result rounded to q16
   function automatic logic [LOG_VAL_W-1:0] log_series(longint unsigned u);
      longint unsigned u2;
      longint unsigned term;
      longint unsigned sum;
      longint unsigned res;
      u2   = (u * u) >> 30;
      term = u;
      sum  = term;
      term = (term * u2) >> 30;  sum = sum + term / 3;
      term = (term * u2) >> 30;  sum = sum + term / 5;
      term = (term * u2) >> 30;  sum = sum + term / 7;
      term = (term * u2) >> 30;  sum = sum + term / 9;
      term = (term * u2) >> 30;  sum = sum + term / 11;
      term = (term * u2) >> 30;  sum = sum + term / 13;
      term = (term * u2) >> 30;  sum = sum + term / 15;
      term = (term * u2) >> 30;  sum = sum + term / 17;
      term = (term * u2) >> 30;  sum = sum + term / 19;
      term = (term * u2) >> 30;  sum = sum + term / 21;
      term = (term * u2) >> 30;  sum = sum + term / 23;
      term = (term * u2) >> 30;  sum = sum + term / 25;
      term = (term * u2) >> 30;  sum = sum + term / 27;
      term = (term * u2) >> 30;  sum = sum + term / 29;
      res = (2 * sum + (64'd1 << 13)) >> 14;
      return res[LOG_VAL_W-1:0];
   endfunction

endpackage

### hw/rtl/dew_point_and_unit_conversion.sv
// dew_point_and_unit_conversion: top level, fahrenheit, kelvin and magnus dew point
// depends on dpc_pkg and dpc_div
//
// Takes one reading (temperature and humidity in tenths) per word and returns
// fahrenheit, kelvin and dew point in tenths plus an invalid flag. The block is
// a single pipeline of 40 register stages: a new word is accepted every cycle
// while the result register is not stalled, and the pipeline includes
// the two one-bit-per-stage dividers (20 stages for the magnus gamma term,
// 12 for the dew point). When the result register is stalled the whole
// pipeline holds. The natural log comes from a table of LOG_TABLE_ENTRIES+1
// points with linear interpolation. Zero humidity, or a dew point below -100.0
// degrees, gives -1000 with the invalid flag set. kelvin_offset is written
// through the csr port and should only change while no word is in flight.
module dew_point_and_unit_conversion #(
   parameter int LOG_TABLE_ENTRIES = dpc_pkg::LOG_TABLE_ENTRIES_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic signed [dpc_pkg::TEMP_W-1:0]   req_temperature,
   input  logic        [dpc_pkg::HUM_W-1:0]    req_humidity,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic signed [dpc_pkg::FAHR_W-1:0]   rsp_fahrenheit,
   output logic signed [dpc_pkg::KELV_W-1:0]   rsp_kelvin,
   output logic signed [dpc_pkg::DEW_W-1:0]    rsp_dew_point,
   output logic                                rsp_invalid,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic signed [dpc_pkg::OFS_W-1:0]    csr_data
);
   import dpc_pkg::*;

   localparam int IDX_W   = $clog2(LOG_TABLE_ENTRIES);
   localparam int TAB_AW  = $clog2(LOG_TABLE_ENTRIES + 1);
   localparam int POS_W   = FRAC_W + IDX_W;
   localparam int EXP_W   = 4;
   localparam int GNUM_W  = 37;
   localparam int GDEN_W  = 19;
   localparam int GQUO_W  = 20;
   localparam int LNQ_W   = 20;
   localparam int K_W     = 23;
   localparam int DPROD_W = 42;
   localparam int DNUM_W  = 40;
   localparam int DDEN_W  = 28;
   localparam int DQUO_W  = 12;

   typedef struct packed {
      logic signed [FAHR_W-1:0] fahrenheit;
      logic signed [KELV_W-1:0] kelvin;
      logic                     zero;
   } carry_type;

   typedef struct packed {
      carry_type               c;
      logic                    neg_t;
      logic signed [LNQ_W-1:0] lnq;
   } gside_type;

   typedef struct packed {
      carry_type c;
      logic      neg_k;
   } dside_type;

   // global advance: the pipeline moves unless the result word is stalled
   logic adv;
   assign adv       = ~rsp_valid | rsp_ready;
   assign req_ready = adv;
   assign csr_ready = 1'b1;

   // offset register
   logic signed [OFS_W-1:0] kelvin_offset_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         kelvin_offset_ff <= OFS_W'(KELVIN_OFFSET_RST);
      end else if (csr_valid) begin
         kelvin_offset_ff <= csr_data;
      end
   end

   // ln table over [1,2] in q16
   logic [LOG_VAL_W-1:0] log_tab [LOG_TABLE_ENTRIES+1];
   for (genvar gi = 0; gi <= LOG_TABLE_ENTRIES; gi++) begin : g_tab
      localparam longint unsigned U =
         (longint'(gi) << 30) / longint'(2 * LOG_TABLE_ENTRIES + gi);
      assign log_tab[gi] = log_series(U);
   end

   // stage 1: capture
   logic                     v1_ff;
   logic signed [TEMP_W-1:0] t1_ff;
   logic [HUM_W-1:0]         h1_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else if (adv) begin
         v1_ff <= req_valid;
      end
   end
   always_ff @(posedge clock) begin
      if (adv) begin
         t1_ff <= req_temperature;
         h1_ff <= req_humidity;
      end
   end

   // fahrenheit: round(9t/5) + 32.0, by reciprocal multiply
   logic signed [14:0]       t9_c;
   logic [13:0]              abs9_c;
   logic [27:0]              q5_prod_c;
   logic [11:0]              q5_c;
   logic signed [12:0]       f13_c;
   logic signed [FAHR_W-1:0] fahr_c;
   assign t9_c      = 15'(t1_ff) * 15'sd9;
   assign abs9_c    = t9_c[14] ? 14'(-t9_c) : 14'(t9_c);
   assign q5_prod_c = (28'(abs9_c) + 28'd2) * 28'(FAHR_RECIP);
   assign q5_c      = q5_prod_c[27:16];
   assign f13_c     = (t9_c[14] ? -$signed({1'b0, q5_c}) : $signed({1'b0, q5_c}))
                      + 13'(FAHR_OFS);
   always_comb begin
      priority if (f13_c > 13'(FAHR_MAX)) begin
         fahr_c = FAHR_W'(FAHR_MAX);
      end else if (f13_c < 13'(FAHR_MIN)) begin
         fahr_c = FAHR_W'(FAHR_MIN);
      end else begin
         fahr_c = f13_c[FAHR_W-1:0];
      end
   end

   // kelvin: t minus offset, saturated
   logic signed [13:0]       kel14_c;
   logic signed [KELV_W-1:0] kel_c;
   assign kel14_c = 14'(t1_ff) - 14'(kelvin_offset_ff);
   always_comb begin
      priority if (kel14_c > 14'(KELV_MAX)) begin
         kel_c = KELV_W'(KELV_MAX);
      end else if (kel14_c < 14'(KELV_MIN)) begin
         kel_c = KELV_W'(KELV_MIN);
      end else begin
         kel_c = kel14_c[KELV_W-1:0];
      end
   end

   // log front end: exponent, mantissa fraction, table position
   logic [EXP_W-1:0]        e_c;
   logic [HUM_W+FRAC_W-1:0] shift_c;
   logic [FRAC_W-1:0]       frac_c;
   logic [POS_W-1:0]        pos_c;
   always_comb begin
      e_c = '0;
      for (int b = 1; b < HUM_W; b++) begin
         if (h1_ff[b]) begin
            e_c = EXP_W'(b);
         end
      end
   end
   assign shift_c = {h1_ff, {FRAC_W{1'b0}}} >> e_c;
   assign frac_c  = shift_c[FRAC_W-1:0];
   assign pos_c   = POS_W'(frac_c) * POS_W'(LOG_TABLE_ENTRIES);

   // gamma operands: |1762*t*65536| over 243120 + 100*t
   logic [TEMP_W-1:0]  tabs_c;
   logic [20:0]        gprod_c;
   logic signed [19:0] gden_c;
   assign tabs_c  = t1_ff[TEMP_W-1] ? TEMP_W'(-t1_ff) : TEMP_W'(t1_ff);
   assign gprod_c = 21'(tabs_c) * 21'(B_X100);
   assign gden_c  = 20'(C_X1000) + 20'(t1_ff) * 20'sd100;

   // stage 2
   logic              v2_ff;
   carry_type         c2_ff;
   logic              negt2_ff;
   logic [EXP_W-1:0]  e2_ff;
   logic [IDX_W-1:0]  idx2_ff;
   logic [FRAC_W-1:0] rem2_ff;
   logic [GNUM_W-1:0] gnum2_ff;
   logic [GDEN_W-1:0] gden2_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else if (adv) begin
         v2_ff <= v1_ff;
      end
   end
   always_ff @(posedge clock) begin
      if (adv) begin
         c2_ff.fahrenheit <= fahr_c;
         c2_ff.kelvin     <= kel_c;
         c2_ff.zero       <= (h1_ff == '0);
         negt2_ff         <= t1_ff[TEMP_W-1];
         e2_ff            <= e_c;
         idx2_ff          <= pos_c[POS_W-1:FRAC_W];
         rem2_ff          <= pos_c[FRAC_W-1:0];
         gnum2_ff         <= {gprod_c, 16'b0};
         gden2_ff         <= gden_c[GDEN_W-1:0];
      end
   end

   // stage 3: table lookup
   logic [TAB_AW-1:0]    lo_addr_c;
   logic                 v3_ff;
   carry_type            c3_ff;
   logic                 negt3_ff;
   logic [EXP_W-1:0]     e3_ff;
   logic [FRAC_W-1:0]    rem3_ff;
   logic [GNUM_W-1:0]    gnum3_ff;
   logic [GDEN_W-1:0]    gden3_ff;
   logic [LOG_VAL_W-1:0] lo3_ff;
   logic [LOG_VAL_W-1:0] diff3_ff;
   assign lo_addr_c = TAB_AW'(idx2_ff);
   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
      end else if (adv) begin
         v3_ff <= v2_ff;
      end
   end
   always_ff @(posedge clock) begin
      if (adv) begin
         c3_ff    <= c2_ff;
         negt3_ff <= negt2_ff;
         e3_ff    <= e2_ff;
         rem3_ff  <= rem2_ff;
         gnum3_ff <= gnum2_ff;
         gden3_ff <= gden2_ff;
         lo3_ff   <= log_tab[lo_addr_c];
         diff3_ff <= log_tab[lo_addr_c + TAB_AW'(1)] - log_tab[lo_addr_c];
      end
   end

   // stage 4: interpolate, ln(h/1000) = e*ln2 + ln(m) - ln(1000)
   logic [30:0]             interp_c;
   logic [20:0]             lnsum_c;
   logic                    v4_ff;
   gside_type               g4_ff;
   logic [GNUM_W-1:0]       gnum4_ff;
   logic [GDEN_W-1:0]       gden4_ff;
   assign interp_c = 31'(diff3_ff) * 31'(rem3_ff);
   assign lnsum_c  = 21'(e3_ff) * 21'(LN2_Q16) + 21'(lo3_ff) + 21'(interp_c[30:15])
                     - 21'(LN1000_Q16);
   always_ff @(posedge clock) begin
      if (reset) begin
         v4_ff <= 1'b0;
      end else if (adv) begin
         v4_ff <= v3_ff;
      end
   end
   always_ff @(posedge clock) begin
      if (adv) begin
         g4_ff.c     <= c3_ff;
         g4_ff.neg_t <= negt3_ff;
         g4_ff.lnq   <= lnsum_c[LNQ_W-1:0];
         gnum4_ff    <= gnum3_ff;
         gden4_ff    <= gden3_ff;
      end
   end

   // gamma divider
   logic              gv_c;
   logic [GQUO_W-1:0] gq_c;
   gside_type         gs_c;
   dpc_div #(
      .NUM_W  (GNUM_W),
      .DEN_W  (GDEN_W),
      .QUO_W  (GQUO_W),
      .SIDE_W ($bits(gside_type))
   ) u_gamma_div (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (v4_ff),
      .in_num    (gnum4_ff),
      .in_den    (gden4_ff),
      .in_side   (g4_ff),
      .out_valid (gv_c),
      .out_quo   (gq_c),
      .out_side  (gs_c)
   );

   // stage 5: k = ln + gamma
   logic signed [K_W-1:0] gam_c;
   logic                  v5_ff;
   carry_type             c5_ff;
   logic signed [K_W-1:0] k5_ff;
   assign gam_c = gs_c.neg_t ? -K_W'(gq_c) : K_W'(gq_c);
   always_ff @(posedge clock) begin
      if (reset) begin
         v5_ff <= 1'b0;
      end else if (adv) begin
         v5_ff <= gv_c;
      end
   end
   always_ff @(posedge clock) begin
      if (adv) begin
         c5_ff <= gs_c.c;
         k5_ff <= K_W'(gs_c.lnq) + gam_c;
      end
   end

   // stage 6: dew numerator 243120*k and denominator 1762*65536 - 100*k
   logic signed [31:0]        dden_c;
   logic                      v6_ff;
   carry_type                 c6_ff;
   logic signed [DPROD_W-1:0] dprod6_ff;
   logic [DDEN_W-1:0]         dden6_ff;
   assign dden_c = 32'(B_Q16) - 32'(k5_ff) * 32'sd100;
   always_ff @(posedge clock) begin
      if (reset) begin
         v6_ff <= 1'b0;
      end else if (adv) begin
         v6_ff <= v5_ff;
      end
   end
   always_ff @(posedge clock) begin
      if (adv) begin
         c6_ff     <= c5_ff;
         dprod6_ff <= DPROD_W'(k5_ff) * DPROD_W'(C_X1000);
         dden6_ff  <= dden_c[DDEN_W-1:0];
      end
   end

   // stage 7: magnitude plus half divisor for rounding
   logic [DNUM_W-1:0] dabs_c;
   logic              v7_ff;
   dside_type         d7_ff;
   logic [DNUM_W-1:0] dnum7_ff;
   logic [DDEN_W-1:0] dden7_ff;
   assign dabs_c = dprod6_ff[DPROD_W-1] ? DNUM_W'(-dprod6_ff) : DNUM_W'(dprod6_ff);
   always_ff @(posedge clock) begin
      if (reset) begin
         v7_ff <= 1'b0;
      end else if (adv) begin
         v7_ff <= v6_ff;
      end
   end
   always_ff @(posedge clock) begin
      if (adv) begin
         d7_ff.c     <= c6_ff;
         d7_ff.neg_k <= dprod6_ff[DPROD_W-1];
         dnum7_ff    <= dabs_c + DNUM_W'(dden6_ff >> 1);
         dden7_ff    <= dden6_ff;
      end
   end

   // dew point divider
   logic              dv_c;
   logic [DQUO_W-1:0] dq_c;
   dside_type         ds_c;
   dpc_div #(
      .NUM_W  (DNUM_W),
      .DEN_W  (DDEN_W),
      .QUO_W  (DQUO_W),
      .SIDE_W ($bits(dside_type))
   ) u_dew_div (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (v7_ff),
      .in_num    (dnum7_ff),
      .in_den    (dden7_ff),
      .in_side   (d7_ff),
      .out_valid (dv_c),
      .out_quo   (dq_c),
      .out_side  (ds_c)
   );

   // output stage: sign, saturation and flag
   logic signed [12:0]      dq13_c;
   logic signed [DEW_W-1:0] dew_c;
   logic                    inv_c;
   assign dq13_c = ds_c.neg_k ? -13'(dq_c) : 13'(dq_c);
   always_comb begin
      priority if (ds_c.c.zero) begin
         dew_c = DEW_W'(DEW_MIN);
         inv_c = 1'b1;
      end else if (dq13_c < 13'(DEW_MIN)) begin
         dew_c = DEW_W'(DEW_MIN);
         inv_c = 1'b1;
      end else if (dq13_c > 13'(DEW_MAX)) begin
         dew_c = DEW_W'(DEW_MAX);
         inv_c = 1'b0;
      end else begin
         dew_c = dq13_c[DEW_W-1:0];
         inv_c = 1'b0;
      end
   end

   logic                     out_vld_ff;
   logic signed [FAHR_W-1:0] out_fahr_ff;
   logic signed [KELV_W-1:0] out_kelv_ff;
   logic signed [DEW_W-1:0]  out_dew_ff;
   logic                     out_inv_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else if (adv) begin
         out_vld_ff <= dv_c;
      end
   end
   always_ff @(posedge clock) begin
      if (adv) begin
         out_fahr_ff <= ds_c.c.fahrenheit;
         out_kelv_ff <= ds_c.c.kelvin;
         out_dew_ff  <= dew_c;
         out_inv_ff  <= inv_c;
      end
   end

   assign rsp_valid      = out_vld_ff;
   assign rsp_fahrenheit = out_fahr_ff;
   assign rsp_kelvin     = out_kelv_ff;
   assign rsp_dew_point  = out_dew_ff;
   assign rsp_invalid    = out_inv_ff;

`ifndef SYNTHESIS
   // flagged results always carry the low saturation value
   a_inv_dew: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_invalid |-> rsp_dew_point == DEW_W'(DEW_MIN))
      else $error("invalid result without saturated dew point");

   // dew point never leaves its lower bound
   a_dew_floor: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_dew_point >= DEW_W'(DEW_MIN))
      else $error("dew point below saturation bound");

   // reset empties the pipeline
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid && !v1_ff)
      else $error("pipeline not empty after reset");

   // an accepted word enters the first stage
   a_capture: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> v1_ff)
      else $error("accepted word lost at capture");
`endif

endmodule

### hw/rtl/dpc_div.sv
// dpc_div: pipelined restoring unsigned divider, one quotient bit per stage
// carries a side word alongside; no package dependencies
module dpc_div #(
   parameter int NUM_W  = 40,
   parameter int DEN_W  = 28,
   parameter int QUO_W  = 12,
   parameter int SIDE_W = 1
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              adv,
   input  logic              in_valid,
   input  logic [NUM_W-1:0]  in_num,
   input  logic [DEN_W-1:0]  in_den,
   input  logic [SIDE_W-1:0] in_side,
   output logic              out_valid,
   output logic [QUO_W-1:0]  out_quo,
   output logic [SIDE_W-1:0] out_side
);

   localparam int CMP_W = ((NUM_W > DEN_W + QUO_W) ? NUM_W : DEN_W + QUO_W) + 1;

   logic [QUO_W-1:0]  vld_ff;
   logic [QUO_W-1:0]  quo_ff  [QUO_W];
   logic [SIDE_W-1:0] side_ff [QUO_W];
   logic [NUM_W-1:0]  rem_ff  [QUO_W-1];
   logic [DEN_W-1:0]  den_ff  [QUO_W-1];

   for (genvar s = 0; s < QUO_W; s++) begin : g_stage
      localparam int BIT = QUO_W - 1 - s;
      logic              vld_src;
      logic [QUO_W-1:0]  quo_src;
      logic [SIDE_W-1:0] side_src;
      logic [NUM_W-1:0]  rem_src;
      logic [DEN_W-1:0]  den_src;
      logic [CMP_W-1:0]  trial_c;
      logic              take_c;

      // stage inputs
      if (s == 0) begin : g_first
         assign vld_src  = in_valid;
         assign quo_src  = '0;
         assign side_src = in_side;
         assign rem_src  = in_num;
         assign den_src  = in_den;
      end else begin : g_next
         assign vld_src  = vld_ff[s-1];
         assign quo_src  = quo_ff[s-1];
         assign side_src = side_ff[s-1];
         assign rem_src  = rem_ff[s-1];
         assign den_src  = den_ff[s-1];
      end

      // trial subtract of the shifted divisor
      assign trial_c = CMP_W'(rem_src) - (CMP_W'(den_src) << BIT);
      assign take_c  = ~trial_c[CMP_W-1];

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[s] <= 1'b0;
         end else if (adv) begin
            vld_ff[s] <= vld_src;
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            quo_ff[s]  <= take_c ? (quo_src | (QUO_W'(1) << BIT)) : quo_src;
            side_ff[s] <= side_src;
         end
      end

      // remainder and divisor are only needed by later stages
      if (s < QUO_W - 1) begin : g_carry
         always_ff @(posedge clock) begin
            if (adv) begin
               rem_ff[s] <= take_c ? trial_c[NUM_W-1:0] : rem_src;
               den_ff[s] <= den_src;
            end
         end
      end
   end

   assign out_valid = vld_ff[QUO_W-1];
   assign out_quo   = quo_ff[QUO_W-1];
   assign out_side  = side_ff[QUO_W-1];

endmodule
